>>> rtl/adc_sample_poll_decode_calibrate_top_defines.svh
// Assertion macros used by the checker file.
`ifndef ADC_SAMPLE_POLL_DECODE_CALIBRATE_TOP_DEFINES_SVH
`define ADC_SAMPLE_POLL_DECODE_CALIBRATE_TOP_DEFINES_SVH

// same-cycle implication
`define ADCPDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ADCPDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/adcpdc_pkg.sv
`default_nettype none

package adcpdc_pkg;

  localparam int unsigned HISTORY_DEPTH  = 8;
  localparam int unsigned CODE_W         = 18;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned DIV_STEPS      = DATA_W;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);

  localparam logic [7:0]  POLL_THRESHOLD = 8'd32;
  localparam logic [7:0]  MASK_18B       = 8'h03;
  localparam logic [7:0]  MASK_14B       = 8'h3f;
  localparam logic [7:0]  MASK_12B       = 8'h0f;
  localparam int unsigned READY_BIT      = 7;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_START   = 1'b1;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ERROR  = 1'b1;

  typedef enum logic [1:0] {
    RES_12 = 2'd0,
    RES_14 = 2'd1,
    RES_16 = 2'd2,
    RES_18 = 2'd3
  } res_e;

  typedef enum logic [1:0] {
    GAIN_X1 = 2'd0,
    GAIN_X2 = 2'd1,
    GAIN_X4 = 2'd2,
    GAIN_X8 = 2'd3
  } gain_e;

  typedef enum logic [1:0] {
    REG_CAL_OFFSET = 2'd0,
    REG_GAIN_MUL   = 2'd1,
    REG_GAIN_DIV   = 2'd2,
    REG_NONE       = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic result;
    logic error;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/adcpdc_ctrl.sv
`default_nettype none

module adcpdc_ctrl
  import adcpdc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.result) begin
          state_d = sts_i.error ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:  cmd_o.mul = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_DONE: cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/adcpdc_dp.sv
`default_nettype none

module adcpdc_dp
  import adcpdc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [DATA_W-1:0]   cfg_data_i,
  input  logic                cmd_i,
  input  logic [7:0]          tick_amount_i,
  input  logic [15:0]         conversion_count_i,
  input  logic [7:0]          rx_byte_first_i,
  input  logic [7:0]          rx_byte_second_i,
  input  logic [7:0]          rx_byte_third_i,
  input  logic [7:0]          rx_byte_fourth_i,
  input  logic                bus_nack_i,
  input  logic                out_ready_i,
  input  dp_cmd_t             ctl_cmd_i,
  output dp_sts_t             sts_o,
  output logic                out_valid_o,
  output logic                kind_o,
  output logic [CODE_W-1:0]   raw_code_o,
  output logic [DATA_W-1:0]   scaled_value_o,
  output logic [1:0]          resolution_code_o,
  output logic [1:0]          gain_code_o,
  output logic                last_sample_o
);

  // configuration
  logic [CODE_W-1:0] cal_offset_q;
  logic [DATA_W-1:0] gain_mul_q;
  logic [DATA_W-1:0] gain_div_q;

  // block state
  logic              running_q;
  logic [7:0]        acc_q;
  logic [15:0]       remaining_q;
  logic [1:0]        res_q;
  logic [1:0]        gain_q;
  logic [CODE_W-1:0] hist_q [HISTORY_DEPTH];

  // per-word work registers
  logic              err_q;
  logic              last_q;
  logic              zero_q;
  logic [CODE_W-1:0] code_q;
  logic [CODE_W-1:0] diff_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  // output register
  logic              out_valid_q;
  logic              kind_q;
  logic [CODE_W-1:0] raw_q;
  logic [DATA_W-1:0] scaled_q;
  logic [1:0]        ores_q;
  logic [1:0]        ogain_q;
  logic              olast_q;

  logic              is_start;
  logic [7:0]        acc_sum;
  logic              poll;
  logic              conv_busy;
  logic [1:0]        res_new;
  logic [CODE_W-1:0] code_new;
  logic              sample;
  logic [CODE_W+DATA_W-1:0] prod;
  logic [DATA_W:0]   trial;
  logic              ge;
  logic [DATA_W:0]   rem_sub;

  assign is_start  = (cmd_i == CMD_START);
  assign acc_sum   = acc_q + tick_amount_i;
  assign poll      = (acc_sum >= POLL_THRESHOLD);
  assign conv_busy = rx_byte_fourth_i[READY_BIT];
  assign res_new   = rx_byte_fourth_i[3:2];
  assign sample    = !is_start && running_q && poll && !bus_nack_i && !conv_busy;

  always_comb begin
    unique case (res_e'(res_new))
      RES_18:  code_new = {rx_byte_first_i[1:0] & MASK_18B[1:0], rx_byte_second_i,
                           rx_byte_third_i};
      RES_16:  code_new = {2'b00, rx_byte_first_i, rx_byte_second_i};
      RES_14:  code_new = {4'h0, rx_byte_first_i[5:0] & MASK_14B[5:0], rx_byte_second_i};
      RES_12:  code_new = {6'h00, rx_byte_first_i[3:0] & MASK_12B[3:0], rx_byte_second_i};
      default: code_new = '0;
    endcase
  end

  always_comb begin
    sts_o.result   = is_start ? bus_nack_i
                              : (running_q && poll && (bus_nack_i || !conv_busy));
    sts_o.error    = bus_nack_i;
    sts_o.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign prod    = diff_q * gain_mul_q;
  assign trial   = {rem_q, quo_q[DATA_W-1]};
  assign ge      = (trial >= {1'b0, gain_div_q});
  assign rem_sub = trial - {1'b0, gain_div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_offset_q <= '0;
      gain_mul_q   <= DATA_W'(1);
      gain_div_q   <= DATA_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CAL_OFFSET: cal_offset_q <= cfg_data_i[CODE_W-1:0];
        REG_GAIN_MUL:   gain_mul_q   <= cfg_data_i;
        REG_GAIN_DIV:   gain_div_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      acc_q       <= '0;
      remaining_q <= '0;
      res_q       <= RES_18;
      gain_q      <= GAIN_X8;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (ctl_cmd_i.load) begin
      if (is_start) begin
        if (!bus_nack_i) begin
          running_q   <= 1'b1;
          remaining_q <= conversion_count_i;
        end
      end else if (running_q) begin
        acc_q <= poll ? 8'd0 : acc_sum;
        if (sample) begin
          res_q  <= res_new;
          gain_q <= rx_byte_fourth_i[1:0];
          for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            hist_q[i] <= hist_q[i-1];
          end
          hist_q[0] <= code_new;
          if (remaining_q == 16'd1) begin
            running_q   <= 1'b0;
            remaining_q <= '0;
          end else if (remaining_q != 16'd0) begin
            remaining_q <= remaining_q - 16'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_cmd_i.load) begin
      err_q  <= bus_nack_i;
      code_q <= code_new;
      last_q <= (remaining_q == 16'd1);
      zero_q <= (code_new <= cal_offset_q);
      diff_q <= code_new - cal_offset_q;
    end
    if (ctl_cmd_i.mul) begin
      quo_q <= prod[DATA_W-1:0];
      rem_q <= '0;
      cnt_q <= '0;
    end else if (ctl_cmd_i.div_step) begin
      quo_q <= {quo_q[DATA_W-2:0], ge};
      rem_q <= ge ? rem_sub[DATA_W-1:0] : trial[DATA_W-1:0];
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_cmd_i.out_load) begin
      kind_q   <= err_q ? KIND_ERROR : KIND_SAMPLE;
      raw_q    <= err_q ? '0 : code_q;
      scaled_q <= (err_q || zero_q) ? '0 : quo_q;
      ores_q   <= err_q ? 2'd0 : res_q;
      ogain_q  <= err_q ? 2'd0 : gain_q;
      olast_q  <= !err_q && last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign raw_code_o        = raw_q;
  assign scaled_value_o    = scaled_q;
  assign resolution_code_o = ores_q;
  assign gain_code_o       = ogain_q;
  assign last_sample_o     = olast_q;

endmodule

`default_nettype wire

>>> rtl/adc_sample_poll_decode_calibrate_top.sv
// A sample word, once accepted, passes through a multiply, 32 steps of the
//   serial divider and one output load before it is valid at the output.
// An error word goes straight to the output load; words with no result give no output.
// One word at a time, held by output stalls: the next word waits for the output load.
// Reset (rst_ni, async low): idle, not running, accumulator and count cleared,
//   18-bit resolution and x8 gain, history zeroed, registers 0 / 1 / 1.
`default_nettype none

module adc_sample_poll_decode_calibrate_top
  import adcpdc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [DATA_W-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [7:0]          tick_amount_i,
  input  logic [15:0]         conversion_count_i,
  input  logic [7:0]          rx_byte_first_i,
  input  logic [7:0]          rx_byte_second_i,
  input  logic [7:0]          rx_byte_third_i,
  input  logic [7:0]          rx_byte_fourth_i,
  input  logic                bus_nack_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                kind_o,
  output logic [CODE_W-1:0]   raw_code_o,
  output logic [DATA_W-1:0]   scaled_value_o,
  output logic [1:0]          resolution_code_o,
  output logic [1:0]          gain_code_o,
  output logic                last_sample_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  adcpdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  adcpdc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .cmd_i              (cmd_i),
    .tick_amount_i      (tick_amount_i),
    .conversion_count_i (conversion_count_i),
    .rx_byte_first_i    (rx_byte_first_i),
    .rx_byte_second_i   (rx_byte_second_i),
    .rx_byte_third_i    (rx_byte_third_i),
    .rx_byte_fourth_i   (rx_byte_fourth_i),
    .bus_nack_i         (bus_nack_i),
    .out_ready_i        (out_ready_i),
    .ctl_cmd_i          (dp_cmd),
    .sts_o              (dp_sts),
    .out_valid_o        (out_valid_o),
    .kind_o             (kind_o),
    .raw_code_o         (raw_code_o),
    .scaled_value_o     (scaled_value_o),
    .resolution_code_o  (resolution_code_o),
    .gain_code_o        (gain_code_o),
    .last_sample_o      (last_sample_o)
  );

endmodule

`default_nettype wire

>>> rtl/adcpdc_checker.sv
`default_nettype none
`include "adc_sample_poll_decode_calibrate_top_defines.svh"

module adcpdc_checker
  import adcpdc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                cmd_i,
  input logic                bus_nack_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                kind_o,
  input logic [CODE_W-1:0]   raw_code_o,
  input logic [DATA_W-1:0]   scaled_value_o,
  input logic [1:0]          resolution_code_o,
  input logic [1:0]          gain_code_o,
  input logic                last_sample_o
);

  `ADCPDC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(scaled_value_o) && $stable(raw_code_o), "result word dropped or changed while stalled")

  `ADCPDC_ASSERT_IMP(a_err_zero, out_valid_o && kind_o == KIND_ERROR, raw_code_o == '0 && scaled_value_o == '0 && resolution_code_o == 2'd0 && gain_code_o == 2'd0 && !last_sample_o, "error word carries nonzero fields")

  `ADCPDC_ASSERT_IMP(a_code_range, out_valid_o && kind_o == KIND_SAMPLE && resolution_code_o != RES_18, raw_code_o[CODE_W-1:CODE_W-2] == 2'b00 && (resolution_code_o != RES_12 || raw_code_o[15:12] == 4'h0) && (resolution_code_o != RES_14 || raw_code_o[15:14] == 2'b00), "code wider than its resolution")

  `ADCPDC_ASSERT_NXT(a_start_quiet, in_valid_i && in_ready_o && cmd_i == CMD_START && !bus_nack_i, !$rose(out_valid_o), "start word produced a result")

endmodule

bind adc_sample_poll_decode_calibrate_top adcpdc_checker u_adcpdc_checker (.*);

`default_nettype wire
